[rtl/sptf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sptf_pkg;

  localparam int unsigned SPINDLES_DEF = 8;

  localparam logic [2:0] CFG_CYCLE_TIME   = 3'd0;
  localparam logic [2:0] CFG_HALF_CT_SQ   = 3'd1;
  localparam logic [2:0] CFG_GAIN_POS     = 3'd2;
  localparam logic [2:0] CFG_GAIN_SPD     = 3'd3;
  localparam logic [2:0] CFG_GAIN_ACC     = 3'd4;
  localparam logic [2:0] CFG_JUMP_LIMIT   = 3'd5;
  localparam logic [2:0] CFG_STEADY_RATIO = 3'd6;
  localparam logic [2:0] CFG_IN_USE       = 3'd7;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] cycle_time;
    logic [31:0] half_ct_sq;
    logic [31:0] gain_pos;
    logic [47:0] gain_spd;
    logic [47:0] gain_acc;
    logic [31:0] jump_limit;
    logic [31:0] steady_ratio;
    logic [3:0]  in_use;
  } cfg_t;

  // Per-spindle record kept in the state memory.
  typedef struct packed {
    logic [63:0] pos;
    logic [47:0] vel;
    logic [55:0] acc;
    logic [15:0] steady;
  } rec_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  // Saturating signed 64-bit add.
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? S64_MIN : S64_MAX;
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  // Clamp a signed 66-bit value to a signed width of w bits, sign-extended to 64.
  function automatic logic [63:0] clamp66(input logic [65:0] v, input int w);
    logic signed [65:0] sv;
    logic signed [65:0] top;
    sv = $signed(v);
    top = (66'sd1 <<< (w - 1)) - 66'sd1;
    if (sv > top) begin
      clamp66 = top[63:0];
    end else if (sv < -top - 66'sd1) begin
      clamp66 = 64'(-top - 66'sd1);
    end else begin
      clamp66 = sv[63:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/sptf_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequential signed-by-unsigned Q32 multiplier: |a| * b built from
// 32x32 partial products, one per cycle, then rounded and saturated.
module sptf_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [47:0] b,
  output logic             done,
  output logic [63:0]      prod,
  output logic [127:0]     raw
);
  logic [63:0]  ma_r;
  logic [47:0]  b_r;
  logic         neg_r;
  logic [2:0]   step_r;
  logic         busy_r;
  logic [127:0] acc_r;
  logic [63:0]  pp;
  logic [127:0] acc_nxt;
  logic [31:0]  aw;
  logic [31:0]  bw;
  logic [6:0]   sh;
  logic [127:0] rnd;
  logic [63:0]  m;

  always_comb begin
    aw = step_r[0] ? ma_r[63:32] : ma_r[31:0];
    bw = step_r[1] ? {16'd0, b_r[47:32]} : b_r[31:0];
    pp = 64'(aw) * 64'(bw);
    sh = {{1'b0, step_r[0]} + {1'b0, step_r[1]}, 5'd0};
    acc_nxt = acc_r + (128'(pp) << sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
        ma_r   <= sptf_pkg::mag64(a);
        neg_r  <= a[63];
        b_r    <= b;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        step_r <= step_r + 3'd1;
        if (step_r == 3'd3) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    raw = acc_r;
    rnd = acc_r + 128'h8000_0000;
    if (rnd[127:96] != 32'd0) begin
      m = 64'hFFFF_FFFF_FFFF_FFFF;
    end else begin
      m = rnd[95:32];
    end
    if (neg_r) begin
      prod = m[63] ? sptf_pkg::S64_MIN : (64'd0 - m);
    end else begin
      prod = m[63] ? sptf_pkg::S64_MAX : m;
    end
  end
endmodule
`default_nettype wire

[rtl/sptf_state_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module sptf_state_mem #(
  parameter int unsigned SPINDLES = sptf_pkg::SPINDLES_DEF,
  parameter int unsigned AW = (SPINDLES > 1) ? $clog2(SPINDLES) : 1
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output sptf_pkg::rec_t     rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire sptf_pkg::rec_t wr_data
);
  sptf_pkg::rec_t mem [SPINDLES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[rtl/spindle_position_tracking_filter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Alpha-beta-gamma tracker for up to SPINDLES spindles. Position, speed,
// acceleration and the steady count of each spindle live in one memory;
// a sample reads its record, runs the update and writes it back before the
// next sample is taken. A first sample passes READ, LOAD, WRITE and OUT
// only; a snap forms three products and a tracked update all seven, each
// formed one at a time by the sequential 64x48 multiplier; a stalled result
// holds off the next acceptance until out_stall drops.
// Samples for a spindle index at or above spindles_in_use give no result.
module spindle_position_tracking_filter_core #(
  parameter int unsigned SPINDLES = sptf_pkg::SPINDLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_spindle_index,
  input  wire logic [63:0] in_encoder_revs,
  input  wire logic        in_reverse,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_out_spindle,
  output logic [63:0]      out_est_position,
  output logic [47:0]      out_est_speed,
  output logic [55:0]      out_est_accel,
  output logic [15:0]      out_steady_count,
  output logic             out_jumped,
  output logic             out_first_sample,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int AW = (SPINDLES > 1) ? $clog2(SPINDLES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_M_VDT, S_M_VT, S_M_AH, S_RES,
    S_M_GP, S_M_GS, S_M_GA, S_M_ST, S_WRITE, S_OUT
  } state_t;

  state_t state_r;
  sptf_pkg::cfg_t cfg_r;
  logic [SPINDLES-1:0] started_r;
  logic [AW-1:0]  k_r;
  logic [2:0]     kin_r;
  logic [63:0]    raw_r, pos_r, pred_r, r_r, vdt_r, tmp_r;
  logic [47:0]    vel_r;
  logic [55:0]    acc_r;
  logic [15:0]    stc_r;
  logic           first_r, jump_r;
  logic           mstart_r;
  logic           mbusy_r;
  logic [63:0]    ma;
  logic [47:0]    mb;
  logic           mdone;
  logic [63:0]    mprod;
  logic [127:0]   mraw;
  sptf_pkg::rec_t rd_rec, wr_rec;
  logic           wr_en;
  logic [63:0]    neg_raw;
  logic [63:0]    vel64, acc64;
  logic [63:0]    negpred;

  assign vel64 = {{16{vel_r[47]}}, vel_r};
  assign acc64 = {{8{acc_r[55]}}, acc_r};
  assign neg_raw = (in_encoder_revs == sptf_pkg::S64_MIN) ? sptf_pkg::S64_MAX
                 : (64'd0 - in_encoder_revs);
  assign negpred = (pred_r == sptf_pkg::S64_MIN) ? sptf_pkg::S64_MAX : (64'd0 - pred_r);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign wr_en     = (state_r == S_WRITE);
  assign wr_rec    = '{pos: pos_r, vel: vel_r, acc: acc_r, steady: stc_r};

  always_comb begin
    ma = acc64;
    mb = 48'(cfg_r.cycle_time);
    case (state_r)
      S_M_VDT: begin ma = acc64; mb = 48'(cfg_r.cycle_time); end
      S_M_VT:  begin ma = vel64; mb = 48'(cfg_r.cycle_time); end
      S_M_AH:  begin ma = acc64; mb = 48'(cfg_r.half_ct_sq); end
      S_M_GP:  begin ma = r_r; mb = 48'(cfg_r.gain_pos); end
      S_M_GS:  begin ma = r_r; mb = cfg_r.gain_spd; end
      S_M_GA:  begin ma = r_r; mb = cfg_r.gain_acc; end
      S_M_ST:  begin ma = vel64; mb = 48'(cfg_r.steady_ratio); end
      default: begin ma = acc64; mb = 48'(cfg_r.cycle_time); end
    endcase
  end

  sptf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart_r), .a(ma), .b(mb),
    .done(mdone), .prod(mprod), .raw(mraw)
  );

  sptf_state_mem #(.SPINDLES(SPINDLES), .AW(AW)) u_mem (
    .clk(clk), .rd_addr(k_r), .rd_data(rd_rec),
    .wr_en(wr_en), .wr_addr(k_r), .wr_data(wr_rec)
  );

  logic [63:0] r_calc;
  logic [63:0] amag;

  always_comb begin
    r_calc = sptf_pkg::sat_add64(raw_r, negpred);
    if (pred_r == sptf_pkg::S64_MIN && r_calc == sptf_pkg::S64_MAX && raw_r[63]) begin
      r_calc = raw_r + sptf_pkg::S64_MAX + 64'd1;
    end
    amag = sptf_pkg::mag64(acc64);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= '0;
      mstart_r  <= 1'b0;
      mbusy_r   <= 1'b0;
      cfg_r.cycle_time   <= 32'd4294967;
      cfg_r.half_ct_sq   <= 32'd2147;
      cfg_r.gain_pos     <= 32'd916425000;
      cfg_r.gain_spd     <= 48'd73237000000;
      cfg_r.gain_acc     <= 48'd3903954000000;
      cfg_r.jump_limit   <= 32'd1073741824;
      cfg_r.steady_ratio <= 32'd1073741824;
      cfg_r.in_use       <= 4'd1;
    end else begin
      mstart_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sptf_pkg::CFG_CYCLE_TIME:   cfg_r.cycle_time   <= cfg_data[31:0];
          sptf_pkg::CFG_HALF_CT_SQ:   cfg_r.half_ct_sq   <= cfg_data[31:0];
          sptf_pkg::CFG_GAIN_POS:     cfg_r.gain_pos     <= cfg_data[31:0];
          sptf_pkg::CFG_GAIN_SPD:     cfg_r.gain_spd     <= cfg_data[47:0];
          sptf_pkg::CFG_GAIN_ACC:     cfg_r.gain_acc     <= cfg_data[47:0];
          sptf_pkg::CFG_JUMP_LIMIT:   cfg_r.jump_limit   <= cfg_data[31:0];
          sptf_pkg::CFG_STEADY_RATIO: cfg_r.steady_ratio <= cfg_data[31:0];
          sptf_pkg::CFG_IN_USE:       cfg_r.in_use       <= cfg_data[3:0];
          default: ;
        endcase
      end
      // Multiply states launch the unit on entry, then wait for done.
      if ((state_r == S_M_VDT || state_r == S_M_VT || state_r == S_M_AH ||
           state_r == S_M_GP || state_r == S_M_GS || state_r == S_M_GA ||
           state_r == S_M_ST) && !mbusy_r && !mstart_r) begin
        mstart_r <= 1'b1;
        mbusy_r  <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kin_r <= in_spindle_index;
            k_r   <= AW'(in_spindle_index);
            raw_r <= in_reverse ? neg_raw : in_encoder_revs;
            if ({1'b0, in_spindle_index} < cfg_r.in_use &&
                32'(in_spindle_index) < 32'(SPINDLES)) begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_LOAD;
        S_LOAD: begin
          jump_r <= 1'b0;
          if (!started_r[k_r]) begin
            started_r[k_r] <= 1'b1;
            pos_r   <= raw_r;
            vel_r   <= '0;
            acc_r   <= '0;
            stc_r   <= '0;
            first_r <= 1'b1;
            state_r <= S_WRITE;
          end else begin
            pos_r   <= rd_rec.pos;
            vel_r   <= rd_rec.vel;
            acc_r   <= rd_rec.acc;
            stc_r   <= rd_rec.steady;
            first_r <= 1'b0;
            state_r <= S_M_VDT;
          end
        end
        S_M_VDT: if (mdone) begin
          mbusy_r <= 1'b0; vdt_r <= mprod; state_r <= S_M_VT;
        end
        S_M_VT: if (mdone) begin
          mbusy_r <= 1'b0; tmp_r <= mprod; state_r <= S_M_AH;
        end
        S_M_AH: if (mdone) begin
          mbusy_r <= 1'b0;
          pred_r  <= sptf_pkg::sat_add64(pos_r, tmp_r + mprod);
          state_r <= S_RES;
        end
        S_RES: begin
          r_r <= r_calc;
          if (sptf_pkg::mag64(r_calc) > 64'(cfg_r.jump_limit)) begin
            pos_r   <= raw_r;
            vel_r   <= 48'(sptf_pkg::clamp66({{2{vel64[63]}}, vel64} +
                                             {{2{vdt_r[63]}}, vdt_r}, 48));
            jump_r  <= 1'b1;
            state_r <= S_WRITE;
          end else begin
            state_r <= S_M_GP;
          end
        end
        S_M_GP: if (mdone) begin
          mbusy_r <= 1'b0;
          pos_r   <= sptf_pkg::sat_add64(pred_r, mprod);
          state_r <= S_M_GS;
        end
        S_M_GS: if (mdone) begin
          mbusy_r <= 1'b0;
          vel_r   <= 48'(sptf_pkg::clamp66({{2{vel64[63]}}, vel64} +
                       {{2{vdt_r[63]}}, vdt_r} + {{2{mprod[63]}}, mprod}, 48));
          state_r <= S_M_GA;
        end
        S_M_GA: if (mdone) begin
          mbusy_r <= 1'b0;
          acc_r   <= 56'(sptf_pkg::clamp66({{2{acc64[63]}}, acc64} +
                       {{2{mprod[63]}}, mprod}, 56));
          state_r <= S_M_ST;
        end
        S_M_ST: if (mdone) begin
          mbusy_r <= 1'b0;
          // mraw holds |vel|*ratio exactly; compare with |acc| << 32.
          if ({32'd0, amag, 32'd0} < mraw) begin
            if (stc_r != 16'hFFFF) stc_r <= stc_r + 16'd1;
          end else begin
            stc_r <= '0;
          end
          state_r <= S_WRITE;
        end
        S_WRITE: state_r <= S_OUT;
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_out_spindle  = kin_r;
  assign out_est_position = pos_r;
  assign out_est_speed    = vel_r;
  assign out_est_accel    = acc_r;
  assign out_steady_count = stc_r;
  assign out_jumped       = jump_r;
  assign out_first_sample = first_r;

`ifndef SYNTH
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_first_not_jump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_first_sample && out_jumped)) else $error("first and jump");
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_sample) |-> (out_steady_count == 16'd0))
    else $error("first sample count");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
